[sv/qrs_pkg.sv]
// Shared constants of the quadratic root solver: status codes, coefficient kinds, field widths.
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int CASE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int USER_W   = 8;
  localparam int KIND_W   = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRIVIAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONTRA  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOREAL  = 2'd3;

  // Nonzero pattern of the coefficients, {a, b, c}.
  localparam logic [KIND_W-1:0] KIND_ZERO = 3'b000;
  localparam logic [KIND_W-1:0] KIND_C    = 3'b001;
  localparam logic [KIND_W-1:0] KIND_B    = 3'b010;
  localparam logic [KIND_W-1:0] KIND_BC   = 3'b011;
  localparam logic [KIND_W-1:0] KIND_A    = 3'b100;
  localparam logic [KIND_W-1:0] KIND_AC   = 3'b101;
  localparam logic [KIND_W-1:0] KIND_AB   = 3'b110;
  localparam logic [KIND_W-1:0] KIND_ABC  = 3'b111;

endpackage

[sv/quadratic_root_solver_unit.sv]
// Top level of the quadratic root solver: decode, products, division and root cell chains.
//
//  channel   | dir | carries
//  s_axis    | in  | tdata: coef_a, coef_b, coef_c
//  m_axis    | out | tdata: roots and ratios; tuser: case, status, flags
//
// One request per cycle while the output is not stalled; a request passes through the quotient-bit
// cells of the two divider chains and the root-bit cells.
// Reset clears only the valid bits; the chain payload carries no reset.
// A stalled output freezes the whole chain; the input register still takes a request
// while it is empty.
`timescale 1ns / 1ps
module quadratic_root_solver_unit
  import qrs_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // coef_a, coef_b, coef_c
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // root_one, root_two, ratio_p, ratio_q
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // case_number, status, ratios_valid, saturated
  output logic [USER_W-1:0]                       m_axis_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int NA     = W + 2*F;
  localparam int DSW    = 2*W + 2;
  localparam int OWR    = (NA > DSW) ? NA : DSW;
  localparam int RW     = (OWR + 1) / 2;
  localparam int OW     = 2*RW;
  localparam int MCW    = ((RW > W) ? RW : W) + 1;
  localparam int ND     = MCW + F;
  localparam int SAT0   = (NA > ND) ? NA : ND;
  localparam int SATW   = (SAT0 > RW) ? SAT0 : RW;
  localparam int OUT_TW = ((4*W+7)/8)*8;
  localparam int L      = NA + RW + ND + 3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              na, nb, nc;
    logic [W-1:0]      ma, mb;
    logic [DSW-1:0]    disc;
    logic              ok;
  } side_a_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              na, nb, nc;
    logic [W-1:0]      ma, mb;
    logic              ok;
    logic [NA-1:0]     q0, q1, q2;
  } side_b_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              na, nb, nc;
    logic              ok, g1, g2;
    logic [NA-1:0]     q0, q1, q2;
    logic [RW-1:0]     s;
  } side_d_t;

  localparam int SA = $bits(side_a_t);
  localparam int SB = $bits(side_b_t);
  localparam int SD = $bits(side_d_t);

  function automatic logic [W:0] sat_f(input logic [SATW-1:0] mag, input logic neg);
    logic [SATW-1:0] lim;
    lim = SATW'(1) << (W-1);
    if (neg) begin
      if (mag > lim) sat_f = {1'b1, 1'b1, {(W-1){1'b0}}};
      else sat_f = {1'b0, W'(0) - mag[W-1:0]};
    end else begin
      if (mag > lim - SATW'(1)) sat_f = {1'b1, 1'b0, {(W-1){1'b1}}};
      else sat_f = {1'b0, mag[W-1:0]};
    end
  endfunction

  // Handshake and valid chain
  logic         adv;
  logic         s_acc;
  logic         v0_q;
  logic [L-1:0] vld_q;

  assign adv           = m_axis_tready | ~vld_q[L-1];
  assign s_axis_tready = adv | ~v0_q;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      vld_q <= '0;
    end else begin
      if (s_acc) v0_q <= 1'b1;
      else if (adv) v0_q <= 1'b0;
      if (adv) vld_q <= {vld_q[L-2:0], v0_q};
    end
  end

  // Input register: sign and magnitude
  logic [W-1:0] va, vb, vc;
  logic         na0_q, nb0_q, nc0_q;
  logic [W-1:0] ma0_q, mb0_q, mc0_q;

  assign va = s_axis_tdata[W-1:0];
  assign vb = s_axis_tdata[2*W-1:W];
  assign vc = s_axis_tdata[3*W-1:2*W];

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      na0_q <= va[W-1];
      nb0_q <= vb[W-1];
      nc0_q <= vc[W-1];
      ma0_q <= va[W-1] ? W'(0) - va : va;
      mb0_q <= vb[W-1] ? W'(0) - vb : vb;
      mc0_q <= vc[W-1] ? W'(0) - vc : vc;
    end
  end

  // Products
  logic              na1_q, nb1_q, nc1_q;
  logic [W-1:0]      ma1_q, mb1_q, mc1_q;
  logic [2*W-1:0]    b2_q, ac_q;
  logic [KIND_W-1:0] kind1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      na1_q <= na0_q;
      nb1_q <= nb0_q;
      nc1_q <= nc0_q;
      ma1_q <= ma0_q;
      mb1_q <= mb0_q;
      mc1_q <= mc0_q;
      b2_q  <= mb0_q * mb0_q;
      ac_q  <= ma0_q * mc0_q;
    end
  end

  assign kind1 = {|ma1_q, |mb1_q, |mc1_q};

  // Discriminant and dividend selection into the first divider chain
  logic [DSW-1:0]          b2e, ac4, disc;
  logic                    disc_ok;
  logic [2:0][NA-1:0]      a_nq [NA+1];
  logic [2:0][W-1:0]       a_rem [NA+1];
  logic [2:0][W-1:0]       a_d [NA+1];
  logic [SA-1:0]           a_sd [NA+1];
  side_a_t                 sa_in, sa_out;

  assign b2e = DSW'(b2_q);
  assign ac4 = {ac_q, 2'b00};

  always_comb begin
    disc    = '0;
    disc_ok = 1'b1;
    if (na1_q != nc1_q) disc = b2e + ac4;
    else if (b2e >= ac4) disc = b2e - ac4;
    else disc_ok = 1'b0;
  end

  always_comb begin
    a_nq[0][1]  = NA'(mb1_q) << F;
    a_nq[0][2]  = NA'(mc1_q) << F;
    a_d[0][1]   = ma1_q;
    a_d[0][2]   = ma1_q;
    a_d[0][0]   = ma1_q;
    a_rem[0]    = '0;
    unique case (kind1)
      KIND_BC: begin
        a_nq[0][0] = NA'(mc1_q) << F;
        a_d[0][0]  = mb1_q;
      end
      KIND_AC: a_nq[0][0] = NA'(mc1_q) << (2*F);
      KIND_AB: a_nq[0][0] = NA'(mb1_q) << F;
      default: a_nq[0][0] = '0;
    endcase
  end

  assign sa_in = '{kind: kind1, na: na1_q, nb: nb1_q, nc: nc1_q, ma: ma1_q, mb: mb1_q,
                   disc: disc, ok: disc_ok};
  assign a_sd[0] = sa_in;

  for (genvar k = 0; k < NA; k++) begin : g_div_a
    qrs_div_cell #(.NW(NA), .DW(W), .LANES(3), .SW(SA)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .nq_i   (a_nq[k]),
      .rem_i  (a_rem[k]),
      .d_i    (a_d[k]),
      .side_i (a_sd[k]),
      .nq_o   (a_nq[k+1]),
      .rem_o  (a_rem[k+1]),
      .d_o    (a_d[k+1]),
      .side_o (a_sd[k+1])
    );
  end

  assign sa_out = side_a_t'(a_sd[NA]);

  // Square root chain
  logic [OW-1:0]   b_op  [RW+1];
  logic [RW+1:0]   b_rem [RW+1];
  logic [RW-1:0]   b_res [RW+1];
  logic [SB-1:0]   b_sd  [RW+1];
  side_b_t         sb_in, sb_out;

  assign b_op[0]  = (sa_out.kind == KIND_AC) ? OW'(a_nq[NA][0]) : OW'(sa_out.disc);
  assign b_rem[0] = '0;
  assign b_res[0] = '0;
  assign sb_in = '{kind: sa_out.kind, na: sa_out.na, nb: sa_out.nb, nc: sa_out.nc,
                   ma: sa_out.ma, mb: sa_out.mb, ok: sa_out.ok,
                   q0: a_nq[NA][0], q1: a_nq[NA][1], q2: a_nq[NA][2]};
  assign b_sd[0] = sb_in;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.RW(RW), .SW(SB)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .op_i   (b_op[k]),
      .rem_i  (b_rem[k]),
      .res_i  (b_res[k]),
      .side_i (b_sd[k]),
      .op_o   (b_op[k+1]),
      .rem_o  (b_rem[k+1]),
      .res_o  (b_res[k+1]),
      .side_o (b_sd[k+1])
    );
  end

  assign sb_out = side_b_t'(b_sd[RW]);

  // Numerators -b +/- sqrt(disc)
  logic [MCW:0]   mbe, sbs, se, n1, n2;
  logic [MCW-1:0] m1_q, m2_q;
  logic [W-1:0]   mac_q;
  side_d_t        sd_c_q;

  assign mbe = (MCW+1)'(sb_out.mb);
  assign sbs = sb_out.nb ? (MCW+1)'(0) - mbe : mbe;
  assign se  = (MCW+1)'(b_res[RW]);
  assign n1  = se - sbs;
  assign n2  = (MCW+1)'(0) - sbs - se;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q   <= n1[MCW] ? MCW'((MCW+1)'(0) - n1) : n1[MCW-1:0];
      m2_q   <= n2[MCW] ? MCW'((MCW+1)'(0) - n2) : n2[MCW-1:0];
      mac_q  <= sb_out.ma;
      sd_c_q <= '{kind: sb_out.kind, na: sb_out.na, nb: sb_out.nb, nc: sb_out.nc,
                  ok: sb_out.ok, g1: n1[MCW], g2: n2[MCW],
                  q0: sb_out.q0, q1: sb_out.q1, q2: sb_out.q2, s: b_res[RW]};
    end
  end

  // Second divider chain: (-b +/- root) / 2a
  logic [1:0][ND-1:0] d_nq  [ND+1];
  logic [1:0][W:0]    d_rem [ND+1];
  logic [1:0][W:0]    d_d   [ND+1];
  logic [SD-1:0]      d_sd  [ND+1];
  side_d_t            sd_out;

  assign d_nq[0][0] = ND'(m1_q) << F;
  assign d_nq[0][1] = ND'(m2_q) << F;
  assign d_rem[0]   = '0;
  assign d_d[0][0]  = {mac_q, 1'b0};
  assign d_d[0][1]  = {mac_q, 1'b0};
  assign d_sd[0]    = sd_c_q;

  for (genvar k = 0; k < ND; k++) begin : g_div_d
    qrs_div_cell #(.NW(ND), .DW(W+1), .LANES(2), .SW(SD)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .nq_i   (d_nq[k]),
      .rem_i  (d_rem[k]),
      .d_i    (d_d[k]),
      .side_i (d_sd[k]),
      .nq_o   (d_nq[k+1]),
      .rem_o  (d_rem[k+1]),
      .d_o    (d_d[k+1]),
      .side_o (d_sd[k+1])
    );
  end

  assign sd_out = side_d_t'(d_sd[ND]);

  // Result select and saturation
  logic [W:0]          sp, sq, s4, s7, s6p, s6n, s8a, s8b;
  logic [STATUS_W-1:0] st_d;
  logic [W-1:0]        r1_d, r2_d, p_d, q_d;
  logic                flag_d;
  logic [4*W-1:0]      out_data_q;
  logic [USER_W-1:0]   out_user_q;

  assign sp  = sat_f(SATW'(sd_out.q1), sd_out.nb ^ sd_out.na);
  assign sq  = sat_f(SATW'(sd_out.q2), sd_out.nc ^ sd_out.na);
  assign s4  = sat_f(SATW'(sd_out.q0), ~sd_out.nc ^ sd_out.nb);
  assign s7  = sat_f(SATW'(sd_out.q0), ~sd_out.nb ^ sd_out.na);
  assign s6p = sat_f(SATW'(sd_out.s), 1'b0);
  assign s6n = sat_f(SATW'(sd_out.s), 1'b1);
  assign s8a = sat_f(SATW'(d_nq[ND][0]), sd_out.g1 ^ sd_out.na);
  assign s8b = sat_f(SATW'(d_nq[ND][1]), sd_out.g2 ^ sd_out.na);

  always_comb begin
    st_d   = ST_OK;
    r1_d   = '0;
    r2_d   = '0;
    p_d    = '0;
    q_d    = '0;
    flag_d = 1'b0;
    if (sd_out.kind[2]) begin
      p_d    = sp[W-1:0];
      q_d    = sq[W-1:0];
      flag_d = sp[W] | sq[W];
    end
    unique case (sd_out.kind)
      KIND_ZERO: st_d = ST_TRIVIAL;
      KIND_C:    st_d = ST_CONTRA;
      KIND_B:    st_d = ST_OK;
      KIND_BC: begin
        r1_d   = s4[W-1:0];
        r2_d   = s4[W-1:0];
        flag_d = flag_d | s4[W];
      end
      KIND_A:    st_d = ST_OK;
      KIND_AC: begin
        if (sd_out.na != sd_out.nc) begin
          r1_d   = s6p[W-1:0];
          r2_d   = s6n[W-1:0];
          flag_d = flag_d | s6p[W] | s6n[W];
        end else begin
          st_d = ST_NOREAL;
        end
      end
      KIND_AB: begin
        r2_d   = s7[W-1:0];
        flag_d = flag_d | s7[W];
      end
      KIND_ABC: begin
        if (sd_out.ok) begin
          r1_d   = s8a[W-1:0];
          r2_d   = s8b[W-1:0];
          flag_d = flag_d | s8a[W] | s8b[W];
        end else begin
          st_d = ST_NOREAL;
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {q_d, p_d, r2_d, r1_d};
      out_user_q <= {flag_d, sd_out.kind[2], st_d, CASE_W'(sd_out.kind) + CASE_W'(1)};
    end
  end

  assign m_axis_tdata = OUT_TW'(out_data_q);
  assign m_axis_tuser = out_user_q;

  // Checks
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v0_q && m_axis_tvalid && !m_axis_tready)
    else $error("input refused while the chain could move");

  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid chain moved during a stall");

  a_noreal_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[5:4] == ST_NOREAL
      |-> m_axis_tuser[3:0] == 4'd6 || m_axis_tuser[3:0] == 4'd8)
    else $error("no-real status outside the quadratic cases");

  a_ratios_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[6] == (m_axis_tuser[3:0] > 4'd4))
    else $error("ratio valid flag disagrees with the case number");

endmodule

[sv/qrs_div_cell.sv]
// One restoring division step per lane: one quotient bit, registered toward the next cell.
`timescale 1ns / 1ps
module qrs_div_cell #(
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [LANES-1:0][NW-1:0]    nq_i,
  input  logic [LANES-1:0][DW-1:0]    rem_i,
  input  logic [LANES-1:0][DW-1:0]    d_i,
  input  logic [SW-1:0]               side_i,
  output logic [LANES-1:0][NW-1:0]    nq_o,
  output logic [LANES-1:0][DW-1:0]    rem_o,
  output logic [LANES-1:0][DW-1:0]    d_o,
  output logic [SW-1:0]               side_o
);

  logic [LANES-1:0][NW-1:0] nq_d, nq_q;
  logic [LANES-1:0][DW-1:0] rem_d, rem_q, d_q;
  logic [SW-1:0]            side_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t         = {rem_i[l], nq_i[l][NW-1]};
    assign ge        = t >= {1'b0, d_i[l]};
    assign diff      = t - {1'b0, d_i[l]};
    assign rem_d[l]  = ge ? diff[DW-1:0] : t[DW-1:0];
    assign nq_d[l]   = {nq_i[l][NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q   <= nq_d;
      rem_q  <= rem_d;
      d_q    <= d_i;
      side_q <= side_i;
    end
  end

  assign nq_o   = nq_q;
  assign rem_o  = rem_q;
  assign d_o    = d_q;
  assign side_o = side_q;

endmodule

[sv/qrs_sqrt_cell.sv]
// One digit-by-digit square root step: two operand bits in, one root bit out, registered.
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
  parameter int RW = 8,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*RW-1:0]   op_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     res_i,
  input  logic [SW-1:0]     side_i,
  output logic [2*RW-1:0]   op_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     res_o,
  output logic [SW-1:0]     side_o
);

  logic [RW+3:0]   rn;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            ge;
  logic [2*RW-1:0] op_q;
  logic [RW+1:0]   rem_d, rem_q;
  logic [RW-1:0]   res_d, res_q;
  logic [SW-1:0]   side_q;

  assign rn    = {rem_i, op_i[2*RW-1 -: 2]};
  assign trial = (RW+4)'({res_i, 2'b01});
  assign ge    = rn >= trial;
  assign diff  = rn - trial;
  assign rem_d = ge ? diff[RW+1:0] : rn[RW+1:0];
  assign res_d = {res_i[RW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= {op_i[2*RW-3:0], 2'b00};
      rem_q  <= rem_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign op_o   = op_q;
  assign rem_o  = rem_q;
  assign res_o  = res_q;
  assign side_o = side_q;

endmodule
